// ----- hw/rtl/trq_pkg.sv -----
// Shared types and constants for the task ready queue.
`default_nettype none

package trq_pkg;

    localparam int ID_W  = 4;
    localparam int KEY_W = 16;
    localparam int OCC_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic MODE_FIFO   = 1'b0;
    localparam logic MODE_SORTED = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic             pop;
        logic             ins;
        logic             sorted;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/task_ready_queue.sv -----
// An item passes from the item register to the result registers and the cell row.
// Throughput: one item per cycle while the result side keeps taking beats.
// Every item is served by a single parallel compare and shift across the cell row.
// Reset clears the entry count, the order mode and all valid flags;
// the cell contents are left as they are and never read before being written.
`default_nettype none

module task_ready_queue #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_command,
    input  wire logic [trq_pkg::ID_W-1:0]  i_task_id,
    input  wire logic [trq_pkg::KEY_W-1:0] i_key,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [trq_pkg::ID_W-1:0]       o_popped_id,
    output logic                           o_overflow,
    output logic [trq_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    logic                      r_mode;
    logic                      r_busy;
    logic                      r_cmd;
    logic [trq_pkg::ID_W-1:0]  r_id;
    logic [trq_pkg::KEY_W-1:0] r_key;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_out_valid;
    logic [trq_pkg::ID_W-1:0]  r_popped_id;
    logic                      r_overflow;
    logic [trq_pkg::OCC_W-1:0] r_occupancy;

    logic                      accept_in;
    logic                      fire;
    logic                      is_pop;
    logic                      full;
    logic                      empty;
    trq_pkg::t_cell_ctl        ctl;

    trq_pkg::t_entry           cell_q [MAX_TASKS];
    logic [MAX_TASKS-1:0]      hit;
    logic [MAX_TASKS-1:0]      occ;

    assign accept_in  = i_in_valid & o_in_ready;
    assign fire       = r_busy & (!r_out_valid | i_out_ready);
    assign o_in_ready = !r_busy | fire;

    assign is_pop = (r_cmd == trq_pkg::CMD_POP);
    assign full   = (r_count == CW'(MAX_TASKS));
    assign empty  = (r_count == '0);

    always_comb begin
        ctl.pop    = fire & is_pop & !empty;
        ctl.ins    = fire & !is_pop & !full;
        ctl.sorted = (r_mode == trq_pkg::MODE_SORTED);
        ctl.id     = r_id;
        ctl.key    = r_key;
    end

    always_comb begin
        n_count = r_count;
        if (ctl.pop) begin
            n_count = r_count - CW'(1);
        end else if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= trq_pkg::MODE_FIFO;
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (accept_in) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            r_count <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the item and the result payloads; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd <= i_command;
            r_id  <= i_task_id;
            r_key <= i_key;
        end
        if (fire) begin
            r_popped_id <= ctl.pop ? cell_q[0].id : '0;
            r_overflow  <= !is_pop & full;
            r_occupancy <= trq_pkg::OCC_W'(n_count);
        end
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        trq_pkg::t_entry below;
        trq_pkg::t_entry above;
        logic            hit_above;
        logic            hit_below;

        assign occ[g] = (r_count > CW'(g));

        if (g == 0) begin : g_first
            assign below     = cell_q[g];
            assign hit_below = 1'b1;
        end else begin : g_mid_lo
            assign below     = cell_q[g-1];
            assign hit_below = hit[g-1];
        end

        if (g == MAX_TASKS - 1) begin : g_last
            assign above     = cell_q[g];
            assign hit_above = 1'b0;
        end else begin : g_mid_hi
            assign above     = cell_q[g+1];
            assign hit_above = hit[g+1];
        end

        trq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_occ       (occ[g]),
            .i_below     (below),
            .i_above     (above),
            .i_hit_above (hit_above),
            .i_hit_below (hit_below),
            .o_entry     (cell_q[g]),
            .o_hit       (hit[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_popped_id = r_popped_id;
    assign o_overflow  = r_overflow;
    assign o_occupancy = r_occupancy;

endmodule

`default_nettype wire

// ----- hw/rtl/trq_cell.sv -----
// One queue slot: holds an entry and trades it with its neighbors on pop or insert.
`default_nettype none

module trq_cell (
    input  wire logic              i_clk,
    input  wire trq_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_occ,
    input  wire trq_pkg::t_entry   i_below,
    input  wire trq_pkg::t_entry   i_above,
    input  wire logic              i_hit_above,
    input  wire logic              i_hit_below,
    output trq_pkg::t_entry        o_entry,
    output logic                   o_hit
);

    trq_pkg::t_entry r_entry;
    trq_pkg::t_entry n_entry;
    logic            le;

    // An occupied slot stays in place if the new entry belongs above it.
    assign le    = i_occ & (!i_ctl.sorted | (r_entry.key <= i_ctl.key));
    assign o_hit = le | i_hit_above;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.pop) begin
            n_entry = i_above;
        end else if (i_ctl.ins && !o_hit) begin
            if (i_hit_below) begin
                n_entry.id  = i_ctl.id;
                n_entry.key = i_ctl.key;
            end else begin
                n_entry = i_below;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire
